// ----- rtl/core/bsa_pkg.sv -----
package bsa_pkg;

  localparam int SLOT_COUNT_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int ADDR_W   = 32;
  localparam int PAGE_W   = 21;
  localparam int CFG_IDX_W = 2;

  // Register reset values
  localparam logic [ADDR_W-1:0] WINDOW_BASE_RST = 32'h4000_0000;
  localparam logic [ADDR_W-1:0] WINDOW_END_RST  = 32'h5000_0000;
  localparam logic [ADDR_W-1:0] USER_TOTAL_RST  = 32'(213 * 1024 * 1024);

  // Page sizes, as reported and as alignment masks
  localparam logic [PAGE_W-1:0] PAGE_SMALL_BYTES = 21'h01_0000;
  localparam logic [PAGE_W-1:0] PAGE_LARGE_BYTES = 21'h10_0000;
  localparam logic [ADDR_W-1:0] PAGE_SMALL_MASK  = 32'h0000_FFFF;
  localparam logic [ADDR_W-1:0] PAGE_LARGE_MASK  = 32'h000F_FFFF;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RESERVE = 2'd1,
    OP_FREE    = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOMEM   = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_BASE = 2'd0,
    CFG_WINDOW_END  = 2'd1,
    CFG_USER_TOTAL  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] request_size;
    logic              large_pages;
    logic [4:0]        align_shift;
    logic [ADDR_W-1:0] target_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] granted_address;
    logic [PAGE_W-1:0] page_bytes;
    logic [ADDR_W-1:0] available_bytes;
  } out_item_t;

  // Classified request as it waits for the back end
  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] align_mask;
    logic              big_page;
    logic [ADDR_W-1:0] target;
  } work_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [ADDR_W-1:0]    data;
  } cfg_wr_t;

endpackage

// ----- rtl/core/bsa_front.sv -----
module bsa_front (
  input  logic             start,
  input  bsa_pkg::in_item_t in_item,
  input  logic             q_full,
  output logic             busy,
  output logic             push,
  output bsa_pkg::work_t   work
);
  import bsa_pkg::*;

  assign busy = q_full;
  assign push = start && !q_full;

  // Classify the op and turn its page or alignment choice into a mask
  always_comb begin
    work.op       = op_t'(in_item.op);
    work.size     = in_item.request_size;
    work.big_page = in_item.large_pages;
    work.target   = in_item.target_address;
    case (op_t'(in_item.op))
      OP_ALLOC: begin
        work.align_mask = in_item.large_pages ? PAGE_LARGE_MASK : PAGE_SMALL_MASK;
      end
      OP_RESERVE: begin
        if (in_item.align_shift == 5'd0) begin
          work.align_mask = PAGE_SMALL_MASK;
        end else begin
          work.align_mask = (ADDR_W'(1) << in_item.align_shift) - ADDR_W'(1);
        end
      end
      default: begin
        work.align_mask = '0;
      end
    endcase
  end

endmodule

// ----- rtl/core/bsa_queue.sv -----
module bsa_queue #(
  parameter int DEPTH = bsa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bsa_pkg::work_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output bsa_pkg::work_t head
);
  import bsa_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  work_t             entry_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign valid = (count_r != '0);
  assign head  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> valid)
    else $error("pop from empty queue");

endmodule

// ----- rtl/core/bsa_back.sv -----
module bsa_back #(
  parameter int SLOT_COUNT = bsa_pkg::SLOT_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bsa_pkg::cfg_wr_t   cfg_wr,
  input  logic               q_valid,
  input  bsa_pkg::work_t     q_item,
  output logic               q_pop,
  output logic               out_valid,
  output bsa_pkg::out_item_t out_item
);
  import bsa_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CALC   = 4'b0010,
    S_PICK   = 4'b0100,
    S_COMMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration and allocator state
  logic [ADDR_W-1:0] window_end_r;
  logic [ADDR_W-1:0] user_total_r;
  logic [ADDR_W-1:0] bump_r, bump_nxt;
  logic [ADDR_W-1:0] held_r, held_nxt;
  logic [SLOT_COUNT-1:0] slot_valid_r, slot_valid_nxt;
  logic [ADDR_W-1:0] slot_start_r  [SLOT_COUNT];
  logic [ADDR_W-1:0] slot_length_r [SLOT_COUNT];
  logic              slot_large_r  [SLOT_COUNT];

  // Per-item working registers
  work_t             item_r;
  logic [ADDR_W:0]   len_r;
  logic [ADDR_W:0]   ptr_r;
  logic [SLOT_COUNT-1:0] free_vec_r, hit_vec_r, in_vec_r;
  logic              fit_r;
  logic              free_found_r, hit_found_r, in_found_r;
  logic [IDX_W-1:0]  free_idx_r, hit_idx_r, in_idx_r;

  logic [IDX_W-1:0]  free_idx_c, hit_idx_c, in_idx_c;
  logic [ADDR_W+1:0] end_sum_c;
  logic [ADDR_W:0]   held_sum_c;
  logic              slot_wr;

  logic              out_valid_r;
  status_t           out_status_r, out_status_nxt;
  logic [ADDR_W-1:0] out_granted_r, out_granted_nxt;
  logic [PAGE_W-1:0] out_page_r, out_page_nxt;

  assign q_pop = (state_r == S_IDLE) && q_valid;

  // Priority pick: lowest set index wins
  always_comb begin
    free_idx_c = '0;
    hit_idx_c  = '0;
    in_idx_c   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (free_vec_r[i]) free_idx_c = IDX_W'(i);
      if (hit_vec_r[i])  hit_idx_c  = IDX_W'(i);
      if (in_vec_r[i])   in_idx_c   = IDX_W'(i);
    end
  end

  assign end_sum_c  = {1'b0, ptr_r} + {1'b0, len_r};
  assign held_sum_c = {1'b0, held_r} + {1'b0, len_r[ADDR_W-1:0]};

  always_comb begin
    state_nxt       = state_r;
    bump_nxt        = bump_r;
    held_nxt        = held_r;
    slot_valid_nxt  = slot_valid_r;
    slot_wr         = 1'b0;
    out_status_nxt  = ST_OK;
    out_granted_nxt = '0;
    out_page_nxt    = '0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) state_nxt = S_CALC;
      end
      S_CALC: begin
        state_nxt = S_PICK;
      end
      S_PICK: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        state_nxt = S_IDLE;
        case (item_r.op)
          OP_ALLOC: begin
            if (len_r == '0) begin
              out_status_nxt = ST_INVALID;
            end else if (!fit_r) begin
              out_status_nxt = ST_NOMEM;
              if (!ptr_r[ADDR_W]) bump_nxt = ptr_r[ADDR_W-1:0];
            end else if (!free_found_r) begin
              out_status_nxt = ST_NOMEM;
              bump_nxt       = ptr_r[ADDR_W-1:0];
            end else begin
              slot_wr                    = 1'b1;
              slot_valid_nxt[free_idx_r] = 1'b1;
              bump_nxt        = ptr_r[ADDR_W-1:0] + len_r[ADDR_W-1:0];
              held_nxt        = held_sum_c[ADDR_W] ? '1 : held_sum_c[ADDR_W-1:0];
              out_granted_nxt = ptr_r[ADDR_W-1:0];
            end
          end
          OP_RESERVE: begin
            if (!fit_r) begin
              out_status_nxt = ST_NOMEM;
              if (!ptr_r[ADDR_W]) bump_nxt = ptr_r[ADDR_W-1:0];
            end else begin
              bump_nxt        = ptr_r[ADDR_W-1:0] + len_r[ADDR_W-1:0];
              out_granted_nxt = ptr_r[ADDR_W-1:0];
            end
          end
          OP_FREE: begin
            if (hit_found_r) begin
              slot_valid_nxt[hit_idx_r] = 1'b0;
              held_nxt = (held_r > slot_length_r[hit_idx_r]) ?
                         held_r - slot_length_r[hit_idx_r] : '0;
            end else begin
              out_status_nxt = ST_INVALID;
            end
          end
          default: begin
            out_page_nxt = (in_found_r && slot_large_r[in_idx_r]) ?
                           PAGE_LARGE_BYTES : PAGE_SMALL_BYTES;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // A base write also reloads the pointer
    if (cfg_wr.we && cfg_idx_t'(cfg_wr.index) == CFG_WINDOW_BASE) begin
      bump_nxt = cfg_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      window_end_r <= WINDOW_END_RST;
      user_total_r <= USER_TOTAL_RST;
      bump_r       <= WINDOW_BASE_RST;
      held_r       <= '0;
      slot_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      held_r       <= held_nxt;
      slot_valid_r <= slot_valid_nxt;
      out_valid_r  <= (state_r == S_COMMIT);
      bump_r       <= bump_nxt;
      if (cfg_wr.we) begin
        case (cfg_idx_t'(cfg_wr.index))
          CFG_WINDOW_END:  window_end_r <= cfg_wr.data;
          CFG_USER_TOTAL:  user_total_r <= cfg_wr.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
    end
    if (state_r == S_CALC) begin
      len_r <= ({1'b0, item_r.size} + {1'b0, item_r.align_mask}) & ~{1'b0, item_r.align_mask};
      ptr_r <= ({1'b0, bump_r} + {1'b0, item_r.align_mask}) & ~{1'b0, item_r.align_mask};
      for (int i = 0; i < SLOT_COUNT; i++) begin
        free_vec_r[i] <= !slot_valid_r[i];
        hit_vec_r[i]  <= slot_valid_r[i] && (slot_start_r[i] == item_r.target);
        in_vec_r[i]   <= slot_valid_r[i] && (item_r.target >= slot_start_r[i]) &&
                         ({1'b0, item_r.target} <
                          ({1'b0, slot_start_r[i]} + {1'b0, slot_length_r[i]}));
      end
    end
    if (state_r == S_PICK) begin
      fit_r        <= (end_sum_c <= {2'b00, window_end_r});
      free_found_r <= |free_vec_r;
      hit_found_r  <= |hit_vec_r;
      in_found_r   <= |in_vec_r;
      free_idx_r   <= free_idx_c;
      hit_idx_r    <= hit_idx_c;
      in_idx_r     <= in_idx_c;
    end
    if (slot_wr) begin
      slot_start_r[free_idx_r]  <= ptr_r[ADDR_W-1:0];
      slot_length_r[free_idx_r] <= len_r[ADDR_W-1:0];
      slot_large_r[free_idx_r]  <= item_r.big_page;
    end
    if (state_r == S_COMMIT) begin
      out_status_r  <= out_status_nxt;
      out_granted_r <= out_granted_nxt;
      out_page_r    <= out_page_nxt;
    end
  end

  // Availability follows the held count, which stays put while the result shows
  assign out_valid                = out_valid_r;
  assign out_item.status          = out_status_r;
  assign out_item.granted_address = out_granted_r;
  assign out_item.page_bytes      = out_page_r;
  assign out_item.available_bytes = (user_total_r > held_r) ? user_total_r - held_r : '0;

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held longer than one cycle");
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_granted_r == '0 && out_page_r == '0))
    else $error("failed result carries an address or page size");

endmodule

// ----- rtl/core/bump_allocator_with_slot_table_unit.sv -----
// Channel | Ports                              | Handshake
// --------+------------------------------------+--------------------------------------
// input   | start, busy, in_item               | item taken when start=1 and busy=0
// result  | out_valid, out_item                | one-cycle strobe, no back-pressure
// config  | cfg_we, cfg_index, cfg_wdata       | write when cfg_we=1, no wait
//
// Each item passes through the back-end sequencer (fetch, align/compare,
// priority pick, commit); its result strobes the cycle after commit. The back
// end pops a new item only from idle, after the last one has committed. A 2-deep
// queue between front and back takes items while the back end works; busy is
// high only when that queue is full. Reset (rst_n, synchronous) restores the
// default window and clears all slot valid bits in the same cycle; no clearing
// pass. The receiver cannot stall.
module bump_allocator_with_slot_table_unit #(
  parameter int SLOT_COUNT  = bsa_pkg::SLOT_COUNT_DEF,
  parameter int QUEUE_DEPTH = bsa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  bsa_pkg::in_item_t                   in_item,
  output logic                                out_valid,
  output bsa_pkg::out_item_t                  out_item,
  input  logic                                cfg_we,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bsa_pkg::ADDR_W-1:0]          cfg_wdata
);
  import bsa_pkg::*;

  logic    q_full;
  logic    q_push;
  logic    q_pop;
  logic    q_valid;
  work_t   q_in;
  work_t   q_head;
  cfg_wr_t cfg_wr;

  // Bundle the register write for the back end, which owns the registers
  assign cfg_wr.we    = cfg_we;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_wdata;

  // Front: take the item and classify it
  bsa_front u_front (
    .start   (start),
    .in_item (in_item),
    .q_full  (q_full),
    .busy    (busy),
    .push    (q_push),
    .work    (q_in)
  );

  // Hold classified items until the back end is free
  bsa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  // Back: bump the pointer, search and update the slot table, drive the result
  bsa_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .q_valid   (q_valid),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
